[rtl/rdp_pkg.sv]
// rdp_pkg: command codes and the controller/datapath link types for rect_disk_prune.
// No dependencies.
package rdp_pkg;

   typedef enum logic [1:0] {
      CMD_LOAD      = 2'd0,
      CMD_INTERSECT = 2'd1,
      CMD_EXCLUDE   = 2'd2,
      CMD_TEST      = 2'd3
   } cmd_type;

   // controller -> datapath
   typedef struct packed {
      logic capture;
      logic mul_load;
      logic mul_step;
      logic sqrt_load;
      logic sqrt_step;
      logic save_t;
      logic save_h;
      logic phase;
      logic apply;
      logic emit;
   } ctl_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic is_load;
      logic is_test;
      logic out_free;
   } ctl_stat_type;

endpackage

[rtl/rdp_req_if.sv]
// rdp_req_if: request channel (valid/ready plus command and disk/rectangle payload).
// Depends on nothing.
interface rdp_req_if #(parameter int W = 32);
   logic                valid;
   logic                ready;
   logic [1:0]          command;
   logic signed [W-1:0] center_x;
   logic signed [W-1:0] center_y;
   logic [W-2:0]        radius;
   logic signed [W-1:0] new_left;
   logic signed [W-1:0] new_bottom;
   logic signed [W-1:0] new_right;
   logic signed [W-1:0] new_top;

   modport source (output valid, command, center_x, center_y, radius,
                   new_left, new_bottom, new_right, new_top, input ready);
   modport sink   (input valid, command, center_x, center_y, radius,
                   new_left, new_bottom, new_right, new_top, output ready);
endinterface

[rtl/rdp_rsp_if.sv]
// rdp_rsp_if: response channel (valid/ready plus rectangle bounds and flags).
// Depends on nothing.
interface rdp_rsp_if #(parameter int W = 32);
   logic                valid;
   logic                ready;
   logic signed [W-1:0] left;
   logic signed [W-1:0] bottom;
   logic signed [W-1:0] right;
   logic signed [W-1:0] top;
   logic                is_empty;
   logic                disk_misses;

   modport source (output valid, left, bottom, right, top, is_empty, disk_misses,
                   input ready);
   modport sink   (input valid, left, bottom, right, top, is_empty, disk_misses,
                   output ready);
endinterface

[rtl/rdp_ctrl.sv]
// rdp_ctrl: sequencer for rect_disk_prune; steps the serial multiplier and square root.
// Depends on rdp_pkg.
module rdp_ctrl #(
   parameter int W = 32
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  rdp_pkg::ctl_stat_type stat,
   output rdp_pkg::ctl_cmd_type  cmd
);

   localparam int CW = $clog2(W);

   typedef enum logic [3:0] {
      ST_IDLE, ST_START, ST_MUL_LOAD, ST_MUL_RUN, ST_MUL_DONE,
      ST_SQRT_RUN, ST_SAVE_H, ST_APPLY, ST_EMIT
   } state_type;

   state_type       state_ff, state_in;
   logic [CW-1:0]   cnt_ff, cnt_in;
   logic            phase_ff, phase_in;
   logic            last;

   assign last      = (cnt_ff == CW'(W - 1));
   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      phase_in = phase_ff;
      cmd      = '0;
      cmd.phase = phase_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_START;
            end
         end
         ST_START: begin
            phase_in = 1'b0;
            state_in = stat.is_load ? ST_APPLY : ST_MUL_LOAD;
         end
         ST_MUL_LOAD: begin
            cmd.mul_load = 1'b1;
            cnt_in       = '0;
            state_in     = ST_MUL_RUN;
         end
         ST_MUL_RUN: begin
            cmd.mul_step = 1'b1;
            cnt_in       = cnt_ff + 1'b1;
            if (last) state_in = ST_MUL_DONE;
         end
         ST_MUL_DONE: begin
            cnt_in = '0;
            if (stat.is_test) begin
               if (!phase_ff) begin
                  cmd.save_t = 1'b1;
                  phase_in   = 1'b1;
                  state_in   = ST_MUL_LOAD;
               end else begin
                  state_in = ST_APPLY;
               end
            end else begin
               cmd.sqrt_load = 1'b1;
               state_in      = ST_SQRT_RUN;
            end
         end
         ST_SQRT_RUN: begin
            cmd.sqrt_step = 1'b1;
            cnt_in        = cnt_ff + 1'b1;
            if (last) begin
               // root is final on this edge; grab the second one in ST_SAVE_H
               state_in = phase_ff ? ST_SAVE_H : ST_MUL_LOAD;
               phase_in = 1'b1;
            end
         end
         ST_SAVE_H: begin
            cmd.save_h = 1'b1;
            state_in   = ST_APPLY;
         end
         ST_APPLY: begin
            cmd.apply = 1'b1;
            state_in  = ST_EMIT;
         end
         ST_EMIT: begin
            if (stat.out_free) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
         phase_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         phase_ff <= phase_in;
      end
   end

endmodule

[rtl/rdp_datapath.sv]
// rdp_datapath: rectangle bounds, captured beat, serial multiplier, serial square root,
// bound update logic and the response register. Depends on rdp_pkg.
module rdp_datapath #(
   parameter int W = 32
) (
   input  logic                 clock,
   input  logic                 reset,
   input  rdp_pkg::ctl_cmd_type  cmd,
   output rdp_pkg::ctl_stat_type stat,
   input  logic [1:0]           req_command,
   input  logic signed [W-1:0]  req_center_x,
   input  logic signed [W-1:0]  req_center_y,
   input  logic [W-2:0]         req_radius,
   input  logic signed [W-1:0]  req_new_left,
   input  logic signed [W-1:0]  req_new_bottom,
   input  logic signed [W-1:0]  req_new_right,
   input  logic signed [W-1:0]  req_new_top,
   input  logic                 rsp_ready,
   output logic                 rsp_valid,
   output logic signed [W-1:0]  rsp_left,
   output logic signed [W-1:0]  rsp_bottom,
   output logic signed [W-1:0]  rsp_right,
   output logic signed [W-1:0]  rsp_top,
   output logic                 rsp_is_empty,
   output logic                 rsp_disk_misses
);

   function automatic logic signed [W:0] sat_ext(input logic signed [W:0] v);
      logic signed [W:0] o;
      if (v[W] != v[W-1]) o = v[W] ? {2'b11, {(W-1){1'b0}}} : {2'b00, {(W-1){1'b1}}};
      else                o = v;
      return o;
   endfunction

   function automatic logic [W:0] mag(input logic signed [W:0] v);
      return v[W] ? (~v + 1'b1) : v;
   endfunction

   function automatic logic signed [W:0] smax(input logic signed [W:0] a,
                                              input logic signed [W:0] b);
      return (a > b) ? a : b;
   endfunction

   function automatic logic signed [W:0] smin(input logic signed [W:0] a,
                                              input logic signed [W:0] b);
      return (a < b) ? a : b;
   endfunction

   // captured beat
   rdp_pkg::cmd_type     op_ff;
   logic signed [W-1:0]  cx_ff, cy_ff, nl_ff, nb_ff, nr_ff, nt_ff;
   logic [W-2:0]         r_ff;

   // rectangle
   logic signed [W-1:0]  lo_x_ff, lo_y_ff, hi_x_ff, hi_y_ff;
   logic signed [W-1:0]  lo_x_in, lo_y_in, hi_x_in, hi_y_in;
   logic                 miss_ff, miss_in;

   // arithmetic units
   logic [2*W-1:0]       prod_ff, t_ff;
   logic [W-1:0]         mcand_ff, h1_ff, h2_ff, root_ff;
   logic [W+1:0]         rem_ff, rem_sh, trial;
   logic [W:0]           msum;

   // response register
   logic                 rsp_valid_ff;
   logic signed [W-1:0]  o_l_ff, o_b_ff, o_r_ff, o_t_ff;
   logic                 o_e_ff, o_m_ff;

   logic signed [W:0]    cx_e, cy_e, lx_e, ly_e, hx_e, hy_e;
   logic signed [W:0]    px, py, h1_e, h2_e, xl1, xh1, yl2, yh2;
   logic signed [W:0]    ex_lx, ex_hx, ex_ly, ex_hy;
   logic signed [W:0]    ix_lx, ix_hx, ix_ly, ix_hy;
   logic [W:0]           q1, q2, r_e, a_op, b_op;
   logic                 ok1, ok2;

   assign cx_e = {cx_ff[W-1], cx_ff};
   assign cy_e = {cy_ff[W-1], cy_ff};
   assign lx_e = {lo_x_ff[W-1], lo_x_ff};
   assign ly_e = {lo_y_ff[W-1], lo_y_ff};
   assign hx_e = {hi_x_ff[W-1], hi_x_ff};
   assign hy_e = {hi_y_ff[W-1], hi_y_ff};
   assign r_e  = {2'b00, r_ff};
   assign h1_e = {1'b0, h1_ff};
   assign h2_e = {1'b0, h2_ff};

   // closest point for intersect/test, farthest edge (hi on a tie) for exclude
   always_comb begin
      if (op_ff == rdp_pkg::CMD_EXCLUDE) begin
         px = (mag(cx_e - hx_e) >= mag(cx_e - lx_e)) ? hx_e : lx_e;
         py = (mag(cy_e - hy_e) >= mag(cy_e - ly_e)) ? hy_e : ly_e;
      end else begin
         px = (cx_e < lx_e) ? lx_e : ((cx_e > hx_e) ? hx_e : cx_e);
         py = (cy_e < ly_e) ? ly_e : ((cy_e > hy_e) ? hy_e : cy_e);
      end
   end

   assign q1  = mag(py - cy_e);
   assign q2  = mag(px - cx_e);
   assign ok1 = (q1 < r_e);
   assign ok2 = (q2 < r_e);

   // phase 0: (r-q1)(r+q1); phase 1: (r-q2)(r+q2), or q2*q2 for test
   always_comb begin
      if (!cmd.phase) begin
         a_op = r_e - q1;
         b_op = r_e + q1;
      end else if (op_ff == rdp_pkg::CMD_TEST) begin
         a_op = q2;
         b_op = q2;
      end else begin
         a_op = r_e - q2;
         b_op = r_e + q2;
      end
   end

   assign msum   = {1'b0, prod_ff[2*W-1:W]} + (prod_ff[0] ? {1'b0, mcand_ff} : '0);
   assign rem_sh = {rem_ff[W-1:0], prod_ff[2*W-1:2*W-2]};
   assign trial  = {root_ff, 2'b01};

   assign xl1 = cx_e - h1_e;
   assign xh1 = cx_e + h1_e;
   assign yl2 = cy_e - h2_e;
   assign yh2 = cy_e + h2_e;

   assign ix_lx = sat_ext(smax(lx_e, xl1));
   assign ix_hx = sat_ext(smin(hx_e, xh1));
   assign ix_ly = sat_ext(smax(ly_e, yl2));
   assign ix_hy = sat_ext(smin(hy_e, yh2));

   // exclude: the second check of an axis sees the bound the first one wrote
   always_comb begin
      ex_lx = lx_e;
      ex_hx = hx_e;
      ex_ly = ly_e;
      ex_hy = hy_e;
      if (ok1) begin
         if (px == lx_e && hx_e <= xh1) ex_hx = sat_ext(smin(hx_e, xl1));
         if (px == ex_hx && lx_e >= xl1) ex_lx = sat_ext(smax(lx_e, xh1));
      end
      if (ok2) begin
         if (py == ly_e && hy_e <= yh2) ex_hy = sat_ext(smin(hy_e, yl2));
         if (py == ex_hy && ly_e >= yl2) ex_ly = sat_ext(smax(ly_e, yh2));
      end
   end

   always_comb begin
      lo_x_in = lo_x_ff;
      lo_y_in = lo_y_ff;
      hi_x_in = hi_x_ff;
      hi_y_in = hi_y_ff;
      miss_in = 1'b0;
      case (op_ff)
         rdp_pkg::CMD_LOAD: begin
            lo_x_in = nl_ff;
            lo_y_in = nb_ff;
            hi_x_in = nr_ff;
            hi_y_in = nt_ff;
         end
         rdp_pkg::CMD_INTERSECT: begin
            if (!ok1 || !ok2) begin
               hi_x_in = lo_x_ff;
            end else begin
               lo_x_in = ix_lx[W-1:0];
               hi_x_in = ix_hx[W-1:0];
               lo_y_in = ix_ly[W-1:0];
               hi_y_in = ix_hy[W-1:0];
            end
         end
         rdp_pkg::CMD_EXCLUDE: begin
            lo_x_in = ex_lx[W-1:0];
            hi_x_in = ex_hx[W-1:0];
            lo_y_in = ex_ly[W-1:0];
            hi_y_in = ex_hy[W-1:0];
         end
         rdp_pkg::CMD_TEST: begin
            // t = r^2 - dy^2, prod = dx^2
            miss_in = (!ok1 || !ok2) ? 1'b1 : (t_ff <= prod_ff);
         end
         default: miss_in = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff <= rdp_pkg::cmd_type'(req_command);
         cx_ff <= req_center_x;
         cy_ff <= req_center_y;
         r_ff  <= req_radius;
         nl_ff <= req_new_left;
         nb_ff <= req_new_bottom;
         nr_ff <= req_new_right;
         nt_ff <= req_new_top;
      end
      if (cmd.mul_load) begin
         prod_ff  <= {{W{1'b0}}, b_op[W-1:0]};
         mcand_ff <= a_op[W-1:0];
      end else if (cmd.mul_step) begin
         prod_ff <= {msum, prod_ff[W-1:1]};
      end else if (cmd.sqrt_step) begin
         prod_ff <= {prod_ff[2*W-3:0], 2'b00};
      end
      if (cmd.sqrt_load) begin
         rem_ff  <= '0;
         root_ff <= '0;
      end else if (cmd.sqrt_step) begin
         if (rem_sh >= trial) begin
            rem_ff  <= rem_sh - trial;
            root_ff <= {root_ff[W-2:0], 1'b1};
         end else begin
            rem_ff  <= rem_sh;
            root_ff <= {root_ff[W-2:0], 1'b0};
         end
      end
      if (cmd.save_t) t_ff <= prod_ff;
      if (cmd.mul_load && cmd.phase) h1_ff <= root_ff;
      if (cmd.save_h) h2_ff <= root_ff;
      if (cmd.emit) begin
         o_l_ff <= lo_x_ff;
         o_b_ff <= lo_y_ff;
         o_r_ff <= hi_x_ff;
         o_t_ff <= hi_y_ff;
         o_e_ff <= (lo_x_ff >= hi_x_ff) || (lo_y_ff >= hi_y_ff);
         o_m_ff <= miss_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lo_x_ff      <= '0;
         lo_y_ff      <= '0;
         hi_x_ff      <= '0;
         hi_y_ff      <= '0;
         miss_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.apply) begin
            lo_x_ff <= lo_x_in;
            lo_y_ff <= lo_y_in;
            hi_x_ff <= hi_x_in;
            hi_y_ff <= hi_y_in;
            miss_ff <= miss_in;
         end
         if (cmd.emit)          rsp_valid_ff <= 1'b1;
         else if (rsp_ready)    rsp_valid_ff <= 1'b0;
      end
   end

   assign stat.is_load  = (op_ff == rdp_pkg::CMD_LOAD);
   assign stat.is_test  = (op_ff == rdp_pkg::CMD_TEST);
   assign stat.out_free = !rsp_valid_ff || rsp_ready;

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_left        = o_l_ff;
   assign rsp_bottom      = o_b_ff;
   assign rsp_right       = o_r_ff;
   assign rsp_top         = o_t_ff;
   assign rsp_is_empty    = o_e_ff;
   assign rsp_disk_misses = o_m_ff;

endmodule

[rtl/rect_disk_prune.sv]
// rect_disk_prune: top level; joins rdp_ctrl and rdp_datapath to the channel interfaces.
// Depends on rdp_pkg, rdp_req_if, rdp_rsp_if, rdp_ctrl, rdp_datapath.
//
//   channel   dir   carries
//   req_bus   in    command, disk centre/radius, rectangle to load
//   rsp_bus   out   bounds after the beat, is_empty, disk_misses
//
// One beat at a time. Intersect/exclude each run two passes of the bit-serial
// multiplier, each followed by the two-bits-per-cycle square root. Test runs two
// multiplies and no square root.
// Synchronous reset clears the rectangle to zero and drops any pending response.
// A stalled response holds the block before it reloads the output register.
module rect_disk_prune #(
   parameter int COORD_WIDTH = 32
) (
   input logic    clock,
   input logic    reset,
   rdp_req_if.sink   req_bus,
   rdp_rsp_if.source rsp_bus
);

   rdp_pkg::ctl_cmd_type  cmd;
   rdp_pkg::ctl_stat_type stat;

   rdp_ctrl #(.W(COORD_WIDTH)) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   rdp_datapath #(.W(COORD_WIDTH)) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .stat            (stat),
      .req_command     (req_bus.command),
      .req_center_x    (req_bus.center_x),
      .req_center_y    (req_bus.center_y),
      .req_radius      (req_bus.radius),
      .req_new_left    (req_bus.new_left),
      .req_new_bottom  (req_bus.new_bottom),
      .req_new_right   (req_bus.new_right),
      .req_new_top     (req_bus.new_top),
      .rsp_ready       (rsp_bus.ready),
      .rsp_valid       (rsp_bus.valid),
      .rsp_left        (rsp_bus.left),
      .rsp_bottom      (rsp_bus.bottom),
      .rsp_right       (rsp_bus.right),
      .rsp_top         (rsp_bus.top),
      .rsp_is_empty    (rsp_bus.is_empty),
      .rsp_disk_misses (rsp_bus.disk_misses)
   );

endmodule
